/* rtl/core/arsc_pkg.sv */
// ----------------------------------------------------------------------------
// arsc_pkg
// Shared constants for the anisotropic radius scaling pipeline.
// ----------------------------------------------------------------------------
package arsc_pkg;

   // default radius word width (Q24.24)
   localparam int unsigned WORD_BITS_DEF = 48;

   // multiplier stages ahead of the root pipe
   localparam int unsigned MULT_STAGES = 2;

endpackage

/* rtl/core/arsc_mult.sv */
// ----------------------------------------------------------------------------
// arsc_mult
// Two-stage full-width unsigned multiplier built from four half-width
// partial products.
// ----------------------------------------------------------------------------
module arsc_mult #(
   parameter int unsigned WORD_BITS = 48
) (
   input  logic                   clock,
   input  logic                   en,
   input  logic [WORD_BITS-1:0]   op_a,
   input  logic [WORD_BITS-1:0]   op_b,
   output logic [2*WORD_BITS-1:0] prod
);
   import arsc_pkg::*;

   localparam int unsigned LO = (WORD_BITS + 1) / 2;
   localparam int unsigned HI = WORD_BITS - LO;
   localparam int unsigned PW = 2 * WORD_BITS;

   logic [2*LO-1:0]    p00_ff, p00_in;
   logic [LO+HI-1:0]   p01_ff, p01_in;
   logic [LO+HI-1:0]   p10_ff, p10_in;
   logic [2*HI-1:0]    p11_ff, p11_in;
   logic [PW-1:0]      prod_ff, prod_in;

   always_comb begin
      p00_in = (2*LO)'(op_a[LO-1:0]) * (2*LO)'(op_b[LO-1:0]);
      p01_in = (LO+HI)'(op_a[LO-1:0]) * (LO+HI)'(op_b[WORD_BITS-1:LO]);
      p10_in = (LO+HI)'(op_a[WORD_BITS-1:LO]) * (LO+HI)'(op_b[LO-1:0]);
      p11_in = (2*HI)'(op_a[WORD_BITS-1:LO]) * (2*HI)'(op_b[WORD_BITS-1:LO]);
   end

   always_comb begin
      prod_in = PW'(p00_ff)
              + (PW'(p01_ff) << LO)
              + (PW'(p10_ff) << LO)
              + (PW'(p11_ff) << (2*LO));
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p00_ff  <= p00_in;
         p01_ff  <= p01_in;
         p10_ff  <= p10_in;
         p11_ff  <= p11_in;
         prod_ff <= prod_in;
      end
   end

   assign prod = prod_ff;

endmodule

/* rtl/core/arsc_sqrt.sv */
// ----------------------------------------------------------------------------
// arsc_sqrt
// Pipelined floor square root, one root bit per stage (restoring,
// two radicand bits consumed per stage).
// ----------------------------------------------------------------------------
module arsc_sqrt #(
   parameter int unsigned WORD_BITS = 48
) (
   input  logic                   clock,
   input  logic                   en,
   input  logic [2*WORD_BITS-1:0] radicand,
   output logic [WORD_BITS-1:0]   root
);
   import arsc_pkg::*;

   localparam int unsigned RW = WORD_BITS + 2;
   localparam int unsigned PW = 2 * WORD_BITS;

   logic [RW-1:0]        rem_ff  [1:WORD_BITS];
   logic [WORD_BITS-1:0] root_ff [1:WORD_BITS];
   logic [PW-1:0]        rad_ff  [1:WORD_BITS];

   for (genvar s = 1; s <= WORD_BITS; s++) begin : g_stage
      logic [RW-1:0]        prev_rem;
      logic [WORD_BITS-1:0] prev_root;
      logic [PW-1:0]        prev_rad;
      logic [RW:0]          acc;
      logic [RW:0]          trial;
      logic                 take;
      logic [RW-1:0]        rem_in;
      logic [WORD_BITS-1:0] root_in;
      logic [PW-1:0]        rad_in;

      if (s == 1) begin : g_first
         assign prev_rem  = '0;
         assign prev_root = '0;
         assign prev_rad  = radicand;
      end else begin : g_next
         assign prev_rem  = rem_ff[s-1];
         assign prev_root = root_ff[s-1];
         assign prev_rad  = rad_ff[s-1];
      end

      always_comb begin
         // remainder never exceeds twice the partial root, so its top bit is 0
         acc     = {prev_rem[RW-2:0], prev_rad[PW-1 -: 2]};
         trial   = {1'b0, prev_root, 2'b01};
         take    = (acc >= trial);
         rem_in  = take ? RW'(acc - trial) : RW'(acc);
         root_in = {prev_root[WORD_BITS-2:0], take};
         rad_in  = {prev_rad[PW-3:0], 2'b00};
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[s]  <= rem_in;
            root_ff[s] <= root_in;
            rad_ff[s]  <= rad_in;
         end
      end
   end

   assign root = root_ff[WORD_BITS];

endmodule

/* rtl/core/arsc_sum.sv */
// ----------------------------------------------------------------------------
// arsc_sum
// Registered saturating three-way sums for the scaled radii.
// ----------------------------------------------------------------------------
module arsc_sum #(
   parameter int unsigned WORD_BITS = 48
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 en,
   input  logic                 in_valid,
   input  logic [WORD_BITS-1:0] rad_a,
   input  logic [WORD_BITS-1:0] rad_b,
   input  logic [WORD_BITS-1:0] rad_c,
   input  logic [WORD_BITS-1:0] g_ab,
   input  logic [WORD_BITS-1:0] g_ac,
   input  logic [WORD_BITS-1:0] g_bc,
   output logic                 out_valid,
   output logic [WORD_BITS-1:0] out_a,
   output logic [WORD_BITS-1:0] out_b,
   output logic [WORD_BITS-1:0] out_c,
   output logic                 out_sat
);
   import arsc_pkg::*;

   localparam int unsigned SW = WORD_BITS + 2;

   logic [SW-1:0]        sa, sb, sc;
   logic                 oa, ob, oc;
   logic [WORD_BITS-1:0] a_ff, a_in, b_ff, b_in, c_ff, c_in;
   logic                 sat_ff, sat_in;
   logic                 valid_ff, valid_in;

   always_comb begin
      sa = SW'(rad_a) + SW'(g_ab) + SW'(g_ac);
      sb = SW'(rad_b) + SW'(g_ab) + SW'(g_bc);
      sc = SW'(rad_c) + SW'(g_ac) + SW'(g_bc);
      oa = |sa[SW-1:WORD_BITS];
      ob = |sb[SW-1:WORD_BITS];
      oc = |sc[SW-1:WORD_BITS];
      a_in   = oa ? '1 : sa[WORD_BITS-1:0];
      b_in   = ob ? '1 : sb[WORD_BITS-1:0];
      c_in   = oc ? '1 : sc[WORD_BITS-1:0];
      sat_in = oa | ob | oc;
      valid_in = in_valid;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         a_ff   <= a_in;
         b_ff   <= b_in;
         c_ff   <= c_in;
         sat_ff <= sat_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_a     = a_ff;
   assign out_b     = b_ff;
   assign out_c     = c_ff;
   assign out_sat   = sat_ff;

endmodule

/* rtl/core/anisotropic_radius_scaling.sv */
// Pipeline from accepted request beat to response beat: 2 multiplier stages,
// one root stage per result bit, one sum stage, one output register.
// Throughput: one beat per cycle; the pipe stalls only while the output skid
// register is occupied. Synchronous reset clears all valid bits.
// ----------------------------------------------------------------------------
// anisotropic_radius_scaling
// Adds to each of three directional spectral radii its two pairwise geometric means, saturating.
// ----------------------------------------------------------------------------
module anisotropic_radius_scaling #(
   parameter int unsigned WORD_BITS = arsc_pkg::WORD_BITS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [WORD_BITS-1:0] req_radius_i,
   input  logic [WORD_BITS-1:0] req_radius_j,
   input  logic [WORD_BITS-1:0] req_radius_k,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [WORD_BITS-1:0] rsp_scaled_i,
   output logic [WORD_BITS-1:0] rsp_scaled_j,
   output logic [WORD_BITS-1:0] rsp_scaled_k,
   output logic                 rsp_saturated
);
   import arsc_pkg::*;

   localparam int unsigned LAT = MULT_STAGES + WORD_BITS;
   localparam int unsigned PW  = 2 * WORD_BITS;

   logic                 adv;
   logic                 valid_ff [0:LAT-1];
   logic [WORD_BITS-1:0] a_ff [0:LAT-1];
   logic [WORD_BITS-1:0] b_ff [0:LAT-1];
   logic [WORD_BITS-1:0] c_ff [0:LAT-1];

   logic [PW-1:0]        p_ab, p_ac, p_bc;
   logic [WORD_BITS-1:0] g_ab, g_ac, g_bc;

   logic                 sum_valid, sum_sat;
   logic [WORD_BITS-1:0] sum_a, sum_b, sum_c;

   logic                 main_v_ff, main_v_in, skid_v_ff, skid_v_in;
   logic [WORD_BITS-1:0] main_a_ff, main_a_in, main_b_ff, main_b_in, main_c_ff, main_c_in;
   logic                 main_s_ff, main_s_in;
   logic [WORD_BITS-1:0] skid_a_ff, skid_a_in, skid_b_ff, skid_b_in, skid_c_ff, skid_c_in;
   logic                 skid_s_ff, skid_s_in;
   logic                 load_main, load_skid, fresh;

   // whole pipe moves unless the skid slot already holds a beat
   assign adv       = !skid_v_ff;
   assign req_ready = adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < LAT; s++) valid_ff[s] <= 1'b0;
      end else if (adv) begin
         valid_ff[0] <= req_valid;
         for (int s = 1; s < LAT; s++) valid_ff[s] <= valid_ff[s-1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         a_ff[0] <= req_radius_i;
         b_ff[0] <= req_radius_j;
         c_ff[0] <= req_radius_k;
         for (int s = 1; s < LAT; s++) begin
            a_ff[s] <= a_ff[s-1];
            b_ff[s] <= b_ff[s-1];
            c_ff[s] <= c_ff[s-1];
         end
      end
   end

   arsc_mult #(.WORD_BITS(WORD_BITS)) u_mult_ab (
      .clock(clock), .en(adv), .op_a(req_radius_i), .op_b(req_radius_j), .prod(p_ab));
   arsc_mult #(.WORD_BITS(WORD_BITS)) u_mult_ac (
      .clock(clock), .en(adv), .op_a(req_radius_i), .op_b(req_radius_k), .prod(p_ac));
   arsc_mult #(.WORD_BITS(WORD_BITS)) u_mult_bc (
      .clock(clock), .en(adv), .op_a(req_radius_j), .op_b(req_radius_k), .prod(p_bc));

   arsc_sqrt #(.WORD_BITS(WORD_BITS)) u_sqrt_ab (
      .clock(clock), .en(adv), .radicand(p_ab), .root(g_ab));
   arsc_sqrt #(.WORD_BITS(WORD_BITS)) u_sqrt_ac (
      .clock(clock), .en(adv), .radicand(p_ac), .root(g_ac));
   arsc_sqrt #(.WORD_BITS(WORD_BITS)) u_sqrt_bc (
      .clock(clock), .en(adv), .radicand(p_bc), .root(g_bc));

   arsc_sum #(.WORD_BITS(WORD_BITS)) u_sum (
      .clock(clock), .reset(reset), .en(adv),
      .in_valid(valid_ff[LAT-1]),
      .rad_a(a_ff[LAT-1]), .rad_b(b_ff[LAT-1]), .rad_c(c_ff[LAT-1]),
      .g_ab(g_ab), .g_ac(g_ac), .g_bc(g_bc),
      .out_valid(sum_valid),
      .out_a(sum_a), .out_b(sum_b), .out_c(sum_c), .out_sat(sum_sat));

   // output register plus skid slot
   always_comb begin
      fresh     = sum_valid && adv;
      load_main = rsp_ready || !main_v_ff;
      load_skid = !load_main && fresh;

      main_v_in = main_v_ff;
      main_a_in = main_a_ff;
      main_b_in = main_b_ff;
      main_c_in = main_c_ff;
      main_s_in = main_s_ff;
      skid_v_in = skid_v_ff;
      skid_a_in = skid_a_ff;
      skid_b_in = skid_b_ff;
      skid_c_in = skid_c_ff;
      skid_s_in = skid_s_ff;

      if (load_main) begin
         skid_v_in = 1'b0;
         main_v_in = skid_v_ff || fresh;
         if (skid_v_ff) begin
            main_a_in = skid_a_ff;
            main_b_in = skid_b_ff;
            main_c_in = skid_c_ff;
            main_s_in = skid_s_ff;
         end else begin
            main_a_in = sum_a;
            main_b_in = sum_b;
            main_c_in = sum_c;
            main_s_in = sum_sat;
         end
      end else if (load_skid) begin
         skid_v_in = 1'b1;
         skid_a_in = sum_a;
         skid_b_in = sum_b;
         skid_c_in = sum_c;
         skid_s_in = sum_sat;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_v_ff <= 1'b0;
         skid_v_ff <= 1'b0;
      end else begin
         main_v_ff <= main_v_in;
         skid_v_ff <= skid_v_in;
      end
   end

   always_ff @(posedge clock) begin
      main_a_ff <= main_a_in;
      main_b_ff <= main_b_in;
      main_c_ff <= main_c_in;
      main_s_ff <= main_s_in;
      skid_a_ff <= skid_a_in;
      skid_b_ff <= skid_b_in;
      skid_c_ff <= skid_c_in;
      skid_s_ff <= skid_s_in;
   end

   assign rsp_valid     = main_v_ff;
   assign rsp_scaled_i  = main_a_ff;
   assign rsp_scaled_j  = main_b_ff;
   assign rsp_scaled_k  = main_c_ff;
   assign rsp_saturated = main_s_ff;

   a_skid_has_main: assert property (@(posedge clock) disable iff (reset)
      skid_v_ff |-> main_v_ff)
      else $error("skid slot full while output register empty");

   a_skid_drains: assert property (@(posedge clock) disable iff (reset)
      (skid_v_ff && rsp_ready) |=> !skid_v_ff)
      else $error("skid slot not drained after output beat");

   a_sat_max: assert property (@(posedge clock) disable iff (reset)
      (main_v_ff && main_s_ff) |->
         (&main_a_ff || &main_b_ff || &main_c_ff))
      else $error("saturation flagged without a clipped sum");

endmodule

/* tb/sv/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Streams radius triples through anisotropic_radius_scaling and compares
// every response beat against a bit-accurate floor-root/saturating predictor.
// ----------------------------------------------------------------------------
module tb_top;

   localparam int unsigned WB = arsc_pkg::WORD_BITS_DEF;
   localparam int unsigned LATENCY = WB + 4;
   localparam longint LIMIT = 400000;

   typedef logic [WB-1:0] word_type;

   typedef struct packed {
      word_type ri;
      word_type rj;
      word_type rk;
   } cell_type;

   typedef struct packed {
      word_type si;
      word_type sj;
      word_type sk;
      logic     sat;
   } scaled_type;

   localparam word_type WMAX = {WB{1'b1}};

   logic     clock = 1'b0;
   logic     reset = 1'b1;
   logic     req_valid = 1'b0;
   logic     req_ready;
   word_type req_radius_i = '0;
   word_type req_radius_j = '0;
   word_type req_radius_k = '0;
   logic     rsp_valid;
   logic     rsp_ready = 1'b0;
   word_type rsp_scaled_i;
   word_type rsp_scaled_j;
   word_type rsp_scaled_k;
   logic     rsp_saturated;

   cell_type   cell_q[$];
   scaled_type scaled_q[$];
   int         mismatches = 0;
   int         beats_in = 0;
   int         beats_out = 0;
   int         sat_seen = 0;
   longint     cycles = 0;
   bit         hold_rsp = 1'b0;
   bit         pause_req = 1'b0;
   bit         req_taken = 1'b0;

   anisotropic_radius_scaling uut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // floor(sqrt(a*b)) over the full double-width product
   function automatic word_type geo_root(word_type a, word_type b);
      logic [2*WB-1:0] prod;
      logic [2*WB-1:0] sq;
      word_type r;
      word_type c;
      prod = a * b;
      r = '0;
      for (int bit_n = WB - 1; bit_n >= 0; bit_n--) begin
         c = r | (word_type'(1) << bit_n);
         sq = c * c;
         if (sq <= prod) r = c;
      end
      return r;
   endfunction

   function automatic word_type clip_sum(word_type x, word_type y, word_type z,
                                         inout logic sat);
      logic [WB+1:0] s;
      s = x + y + z;
      if (s > WMAX) begin
         sat = 1'b1;
         return WMAX;
      end
      return s[WB-1:0];
   endfunction

   function automatic scaled_type scale_cell(cell_type c);
      scaled_type r;
      word_type gij, gik, gjk;
      logic sat;
      gij = geo_root(c.ri, c.rj);
      gik = geo_root(c.ri, c.rk);
      gjk = geo_root(c.rj, c.rk);
      sat = 1'b0;
      r.si = clip_sum(c.ri, gij, gik, sat);
      r.sj = clip_sum(c.rj, gij, gjk, sat);
      r.sk = clip_sum(c.rk, gik, gjk, sat);
      r.sat = sat;
      return r;
   endfunction

   function automatic word_type rand_word();
      word_type w;
      w = word_type'({$urandom(), $urandom()});
      case ($urandom_range(0, 7))
         0: w = '0;
         1: w = WMAX;
         2: w = w >> $urandom_range(0, WB - 1);
         3: w = w & 48'h0000_00FF_FFFF;
         4: w = w | 48'hF000_0000_0000;
         default: ;
      endcase
      return w;
   endfunction

   function automatic int gap_len();
      int p;
      p = $urandom_range(0, 99);
      if (p < 55) return 0;
      if (p < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // request beat taken at this edge
   always @(posedge clock) begin
      req_taken = !reset && req_valid && req_ready;
      if (req_taken) begin
         scaled_q.push_back(scale_cell({req_radius_i, req_radius_j, req_radius_k}));
         beats_in++;
      end
   end

   // request driver
   int req_gap = 0;
   always @(negedge clock) begin
      if (!reset) begin
         if (!req_valid || req_taken) begin
            if (req_gap > 0) begin
               req_gap--;
               req_valid <= 1'b0;
            end else if (cell_q.size() > 0 && !pause_req) begin
               cell_type c;
               c = cell_q.pop_front();
               req_valid <= 1'b1;
               req_radius_i <= c.ri;
               req_radius_j <= c.rj;
               req_radius_k <= c.rk;
               req_gap = gap_len();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // response stall pattern
   int rsp_gap = 0;
   always @(negedge clock) begin
      if (hold_rsp) begin
         rsp_ready <= 1'b0;
      end else if (rsp_gap > 0) begin
         rsp_gap--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
         rsp_gap = ($urandom_range(0, 3) == 0) ? gap_len() : 0;
      end
   end

   // monitor
   always @(posedge clock) begin
      cycles++;
      if (!reset && rsp_valid && rsp_ready) begin
         beats_out++;
         if (scaled_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected response beat at cycle %0d", cycles);
         end else begin
            scaled_type e;
            e = scaled_q.pop_front();
            if (rsp_saturated) sat_seen++;
            if (rsp_scaled_i !== e.si || rsp_scaled_j !== e.sj ||
                rsp_scaled_k !== e.sk || rsp_saturated !== e.sat) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch beat %0d: exp %h %h %h %b got %h %h %h %b", beats_out,
                     e.si, e.sj, e.sk, e.sat,
                     rsp_scaled_i, rsp_scaled_j, rsp_scaled_k, rsp_saturated);
            end
         end
      end
      if (cycles > LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("TEST FAILED");
         $finish;
      end
   end

   task automatic add_cell(word_type a, word_type b, word_type c);
      cell_q.push_back('{ri: a, rj: b, rk: c});
   endtask

   task automatic drain();
      while (cell_q.size() > 0 || req_valid || scaled_q.size() > 0) @(posedge clock);
   endtask

   initial begin
      // directed: zeros, ones, extremes, saturation, perfect squares
      add_cell('0, '0, '0);
      add_cell(WMAX, WMAX, WMAX);
      add_cell(WMAX, '0, '0);
      add_cell('0, WMAX, '0);
      add_cell('0, '0, WMAX);
      add_cell(48'd1, 48'd1, 48'd1);
      add_cell(48'h1_000000, 48'h4_000000, 48'h9_000000);
      add_cell(48'h1_000000, '0, 48'h1_000000);
      add_cell(48'h5555_5555_5555, 48'h5555_5555_5555, 48'h5555_5555_5555);
      add_cell(48'h5555_5555_5554, 48'd1, 48'd1);
      add_cell(48'hAAAA_AAAA_AAAA, 48'h5555_5555_5555, 48'd0);
      add_cell(48'h8000_0000_0000, 48'h8000_0000_0000, 48'd0);
      add_cell(48'h7FFF_FFFF_FFFF, 48'd2, 48'h7FFF_FFFF_FFFF);
      add_cell(WMAX, 48'd1, 48'd0);
      add_cell(48'd3, 48'd5, 48'd7);
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      drain();

      // receiver holds off while sender keeps offering
      hold_rsp = 1'b1;
      repeat (120) add_cell(rand_word(), rand_word(), rand_word());
      repeat (300) @(posedge clock);
      hold_rsp = 1'b0;
      drain();

      for (int n = 0; n < 1400; n++) begin
         add_cell(rand_word(), rand_word(), rand_word());
         if (n == 700) begin
            // sender pause until everything has come back
            while (cell_q.size() > 0 || req_valid) @(posedge clock);
            pause_req = 1'b1;
            while (scaled_q.size() > 0) @(posedge clock);
            pause_req = 1'b0;
         end
      end
      drain();
      repeat (LATENCY + 10) @(posedge clock);
      $display("sent %0d cells, checked %0d responses, %0d saturated", beats_in, beats_out,
         sat_seen);
      $display("covered zero/max radii, saturation, long output stall and input pause");
      if (mismatches == 0 && scaled_q.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("%0d mismatches, %0d left over", mismatches, scaled_q.size());
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
